### rtl/core/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg: shared types and constants for the depth pixel to world point block
// Register codes, field widths and configuration structs used across modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpw_pkg;

   // Field widths
   localparam int DEPTH_W  = 16;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 9;
   localparam int INV_W    = 24;
   localparam int CENTER_W = 14;
   localparam int WORLD_W  = 19;
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;

   // Camera point widths (Q.8 mm)
   localparam int PXY_W = 35;
   localparam int PZ_W  = 25;

   // Register codes (index within the register map, 8-byte spacing)
   typedef enum logic [2:0] {
      REG_INV_FOCAL_X = 3'd0,
      REG_INV_FOCAL_Y = 3'd1,
      REG_CENTER_X    = 3'd2,
      REG_CENTER_Y    = 3'd3,
      REG_POSE_ROW_X  = 3'd4,
      REG_POSE_ROW_Y  = 3'd5,
      REG_POSE_ROW_Z  = 3'd6
   } reg_index_type;

   // Intrinsics: reciprocal focal lengths (Q0.24) and principal point (Q10.4)
   typedef struct packed {
      logic [INV_W-1:0]    inv_fx;
      logic [INV_W-1:0]    inv_fy;
      logic [CENTER_W-1:0] cx;
      logic [CENTER_W-1:0] cy;
   } camera_cfg_type;

   // One transform row: three Q2.14 rotation terms, then translation in mm
   typedef struct packed {
      logic signed [15:0] r0;
      logic signed [15:0] r1;
      logic signed [15:0] r2;
      logic signed [15:0] t;
   } pose_row_type;

   // Reset values (identity pose, default intrinsics)
   localparam logic [INV_W-1:0]    INV_FOCAL_RST = 24'd31957;
   localparam logic [CENTER_W-1:0] CENTER_X_RST  = 14'd5120;
   localparam logic [CENTER_W-1:0] CENTER_Y_RST  = 14'd3840;
   localparam logic [63:0]         POSE_X_RST    = 64'h4000_0000_0000_0000;
   localparam logic [63:0]         POSE_Y_RST    = 64'h0000_4000_0000_0000;
   localparam logic [63:0]         POSE_Z_RST    = 64'h0000_0000_4000_0000;

endpackage

`default_nettype wire

### rtl/core/dpw_csr.sv
// ----------------------------------------------------------------------------
// dpw_csr: configuration register file
// APB-style register bank holding intrinsics and the three transform rows.
// ----------------------------------------------------------------------------
`default_nettype none

module dpw_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [dpw_pkg::CSR_AW-1:0] paddr,
   input  wire logic [dpw_pkg::CSR_DW-1:0] pwdata,
   output logic      [dpw_pkg::CSR_DW-1:0] prdata,
   output logic                            pready,
   output dpw_pkg::camera_cfg_type         cam,
   output dpw_pkg::pose_row_type           pose_x,
   output dpw_pkg::pose_row_type           pose_y,
   output dpw_pkg::pose_row_type           pose_z
);
   import dpw_pkg::*;

   camera_cfg_type cam_ff;
   pose_row_type   pose_x_ff, pose_y_ff, pose_z_ff;
   reg_index_type  idx;
   logic           wr_en;

   assign idx    = reg_index_type'(paddr[CSR_AW-1:3]);
   assign wr_en  = psel & penable & pwrite & pready;
   assign pready = 1'b1;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff.inv_fx <= INV_FOCAL_RST;
         cam_ff.inv_fy <= INV_FOCAL_RST;
         cam_ff.cx     <= CENTER_X_RST;
         cam_ff.cy     <= CENTER_Y_RST;
         pose_x_ff     <= pose_row_type'(POSE_X_RST);
         pose_y_ff     <= pose_row_type'(POSE_Y_RST);
         pose_z_ff     <= pose_row_type'(POSE_Z_RST);
      end else if (wr_en) begin
         case (idx)
            REG_INV_FOCAL_X: cam_ff.inv_fx <= pwdata[INV_W-1:0];
            REG_INV_FOCAL_Y: cam_ff.inv_fy <= pwdata[INV_W-1:0];
            REG_CENTER_X:    cam_ff.cx     <= pwdata[CENTER_W-1:0];
            REG_CENTER_Y:    cam_ff.cy     <= pwdata[CENTER_W-1:0];
            REG_POSE_ROW_X:  pose_x_ff     <= pose_row_type'(pwdata);
            REG_POSE_ROW_Y:  pose_y_ff     <= pose_row_type'(pwdata);
            REG_POSE_ROW_Z:  pose_z_ff     <= pose_row_type'(pwdata);
            default: ;
         endcase
      end
   end

   // Read back, zero-extended
   always_comb begin
      case (idx)
         REG_INV_FOCAL_X: prdata = {{(CSR_DW-INV_W){1'b0}}, cam_ff.inv_fx};
         REG_INV_FOCAL_Y: prdata = {{(CSR_DW-INV_W){1'b0}}, cam_ff.inv_fy};
         REG_CENTER_X:    prdata = {{(CSR_DW-CENTER_W){1'b0}}, cam_ff.cx};
         REG_CENTER_Y:    prdata = {{(CSR_DW-CENTER_W){1'b0}}, cam_ff.cy};
         REG_POSE_ROW_X:  prdata = pose_x_ff;
         REG_POSE_ROW_Y:  prdata = pose_y_ff;
         REG_POSE_ROW_Z:  prdata = pose_z_ff;
         default:         prdata = '0;
      endcase
   end

   assign cam    = cam_ff;
   assign pose_x = pose_x_ff;
   assign pose_y = pose_y_ff;
   assign pose_z = pose_z_ff;

endmodule

`default_nettype wire

### rtl/core/dpw_backproject.sv
// ----------------------------------------------------------------------------
// dpw_backproject: pinhole back-projection pipeline
// Four stages: offset, depth multiply, focal multiply, round to Q.8 mm.
// ----------------------------------------------------------------------------
`default_nettype none

module dpw_backproject (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire logic        [dpw_pkg::DEPTH_W-1:0] depth_mm,
   input  wire logic        [dpw_pkg::COL_W-1:0]   column,
   input  wire logic        [dpw_pkg::ROW_W-1:0]   row_index,
   input  wire dpw_pkg::camera_cfg_type            cam,
   output logic                                    out_valid,
   output logic signed      [dpw_pkg::PXY_W-1:0]   px,
   output logic signed      [dpw_pkg::PXY_W-1:0]   py,
   output logic signed      [dpw_pkg::PZ_W-1:0]    pz
);
   import dpw_pkg::*;

   localparam int DXY_W  = CENTER_W + 1;        // pixel offset, Q.4
   localparam int DD_W   = DXY_W + DEPTH_W;     // offset times depth
   localparam int PRD_W  = DD_W + INV_W;        // Q.28 mm product
   localparam int RSH    = 20;                  // Q.28 to Q.8

   logic [3:0] valid_ff;

   // Stage 1: offset from principal point
   logic signed [DXY_W-1:0]   dx_ff, dy_ff, dx_in, dy_in;
   logic        [DEPTH_W-1:0] d1_ff, d2_ff, d3_ff;

   assign dx_in = $signed({1'b0, column, 4'b0000}) - $signed({1'b0, cam.cx});
   assign dy_in = $signed({{(DXY_W-ROW_W-4){1'b0}}, row_index, 4'b0000})
                - $signed({1'b0, cam.cy});

   // Stage 2: multiply by depth
   logic signed [DD_W:0]   dxd_full, dyd_full;
   logic signed [DD_W-1:0] dxd_ff, dyd_ff;

   assign dxd_full = dx_ff * $signed({1'b0, d1_ff});
   assign dyd_full = dy_ff * $signed({1'b0, d1_ff});

   // Stage 3: multiply by reciprocal focal length
   logic signed [PRD_W:0]   prx_full, pry_full;
   logic signed [PRD_W-1:0] prx_ff, pry_ff;

   assign prx_full = dxd_ff * $signed({1'b0, cam.inv_fx});
   assign pry_full = dyd_ff * $signed({1'b0, cam.inv_fy});

   // Stage 4: round half up to Q.8 mm, form z
   logic signed [PRD_W:0]   rx_sum, ry_sum;
   logic signed [PXY_W-1:0] px_ff, py_ff;
   logic signed [PZ_W-1:0]  pz_ff, pz_in;

   assign rx_sum = {prx_ff[PRD_W-1], prx_ff} + $signed((PRD_W+1)'(1) <<< (RSH-1));
   assign ry_sum = {pry_ff[PRD_W-1], pry_ff} + $signed((PRD_W+1)'(1) <<< (RSH-1));
   assign pz_in  = -$signed({1'b0, d3_ff, 8'h00});

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         d1_ff  <= depth_mm;
         dxd_ff <= dxd_full[DD_W-1:0];
         dyd_ff <= dyd_full[DD_W-1:0];
         d2_ff  <= d1_ff;
         prx_ff <= prx_full[PRD_W-1:0];
         pry_ff <= pry_full[PRD_W-1:0];
         d3_ff  <= d2_ff;
         px_ff  <= rx_sum[RSH+PXY_W-1:RSH];
         py_ff  <= ry_sum[RSH+PXY_W-1:RSH];
         pz_ff  <= pz_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign px        = px_ff;
   assign py        = py_ff;
   assign pz        = pz_ff;

endmodule

`default_nettype wire

### rtl/core/dpw_row.sv
// ----------------------------------------------------------------------------
// dpw_row: one row of the rigid transform
// Three stages: rotation products, sum with translation and rounding, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module dpw_row (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire dpw_pkg::pose_row_type              pose,
   input  wire logic signed [dpw_pkg::PXY_W-1:0]   px,
   input  wire logic signed [dpw_pkg::PXY_W-1:0]   py,
   input  wire logic signed [dpw_pkg::PZ_W-1:0]    pz,
   output logic signed      [dpw_pkg::WORLD_W-1:0] world,
   output logic                                    clip
);
   import dpw_pkg::*;

   localparam int PXY_PW = PXY_W + 16;   // Q.22 product of x or y
   localparam int PZ_PW  = PZ_W + 16;    // Q.22 product of z
   localparam int ACC_W  = PXY_PW + 2;   // sum of four terms
   localparam int FRAC   = 22;
   localparam int W_W    = ACC_W - FRAC;

   localparam logic signed [W_W-1:0] OUT_MAX = W_W'((1 << (WORLD_W-1)) - 1);
   localparam logic signed [W_W-1:0] OUT_MIN = -W_W'(1 << (WORLD_W-1));

   // Stage 1: rotation products
   logic signed [PXY_PW-1:0] p0_ff, p1_ff;
   logic signed [PZ_PW-1:0]  p2_ff;
   logic signed [15:0]       t_ff;

   // Stage 2: accumulate, round half up to whole mm
   logic signed [ACC_W-1:0] acc_in;
   logic signed [W_W-1:0]   w_ff;

   assign acc_in = ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff)
                 + (ACC_W'(t_ff) <<< FRAC) + (ACC_W'(1) <<< (FRAC-1));

   // Stage 3: clamp to output range
   logic signed [WORLD_W-1:0] world_ff, world_in;
   logic                      clip_ff, clip_in;

   always_comb begin
      if (w_ff > OUT_MAX) begin
         world_in = OUT_MAX[WORLD_W-1:0];
         clip_in  = 1'b1;
      end else if (w_ff < OUT_MIN) begin
         world_in = OUT_MIN[WORLD_W-1:0];
         clip_in  = 1'b1;
      end else begin
         world_in = w_ff[WORLD_W-1:0];
         clip_in  = 1'b0;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff    <= pose.r0 * px;
         p1_ff    <= pose.r1 * py;
         p2_ff    <= pose.r2 * pz;
         t_ff     <= pose.t;
         w_ff     <= acc_in[ACC_W-1:FRAC];
         world_ff <= world_in;
         clip_ff  <= clip_in;
      end
   end

   assign world = world_ff;
   assign clip  = clip_ff;

endmodule

`default_nettype wire

### rtl/core/depth_pixel_to_world_point_top.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_top: depth pixel to world point converter
// Back-projects a depth pixel through a pinhole camera and applies a rigid
// transform, giving a saturated world point in millimetres.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The pipeline takes a new pixel every clock while
// req_stall is low, returning its world point after four back-projection
// stages (offset, depth multiply, focal multiply, rounding) and three
// transform stages (rotation products, sum and rounding, clamp). The output
// register is the last stage; while it holds a beat under rsp_stall the whole
// pipeline holds, and req_stall follows. Registers must be written over the
// APB port only while the pipeline is empty, which the block does not enforce.
// Register i sits at byte address 8*i; writes to unused addresses are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_to_world_point_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Pixel channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic        [dpw_pkg::DEPTH_W-1:0] req_depth_mm,
   input  wire logic        [dpw_pkg::COL_W-1:0]   req_column,
   input  wire logic        [dpw_pkg::ROW_W-1:0]   req_row_index,
   // Point channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed      [dpw_pkg::WORLD_W-1:0] rsp_world_x,
   output logic signed      [dpw_pkg::WORLD_W-1:0] rsp_world_y,
   output logic signed      [dpw_pkg::WORLD_W-1:0] rsp_world_z,
   output logic                                    rsp_clipped,
   // Configuration port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic        [dpw_pkg::CSR_AW-1:0]  paddr,
   input  wire logic        [dpw_pkg::CSR_DW-1:0]  pwdata,
   output logic             [dpw_pkg::CSR_DW-1:0]  prdata,
   output logic                                    pready
);
   import dpw_pkg::*;

   camera_cfg_type cam;
   pose_row_type   pose_x, pose_y, pose_z;

   logic                      en;
   logic                      bp_valid;
   logic signed [PXY_W-1:0]   px, py;
   logic signed [PZ_W-1:0]    pz;
   logic [2:0]                valid_ff;
   logic                      clip_x, clip_y, clip_z;

   // Hold every stage while the output beat waits
   assign en        = ~valid_ff[2] | ~rsp_stall;
   assign req_stall = ~en;

   dpw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cam     (cam),
      .pose_x  (pose_x),
      .pose_y  (pose_y),
      .pose_z  (pose_z)
   );

   dpw_backproject u_backproject (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .depth_mm  (req_depth_mm),
      .column    (req_column),
      .row_index (req_row_index),
      .cam       (cam),
      .out_valid (bp_valid),
      .px        (px),
      .py        (py),
      .pz        (pz)
   );

   dpw_row u_row_x (
      .clock (clock),
      .en    (en),
      .pose  (pose_x),
      .px    (px),
      .py    (py),
      .pz    (pz),
      .world (rsp_world_x),
      .clip  (clip_x)
   );

   dpw_row u_row_y (
      .clock (clock),
      .en    (en),
      .pose  (pose_y),
      .px    (px),
      .py    (py),
      .pz    (pz),
      .world (rsp_world_y),
      .clip  (clip_y)
   );

   dpw_row u_row_z (
      .clock (clock),
      .en    (en),
      .pose  (pose_z),
      .px    (px),
      .py    (py),
      .pz    (pz),
      .world (rsp_world_z),
      .clip  (clip_z)
   );

   // Advance valid bits through the transform stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], bp_valid};
      end
   end

   assign rsp_valid   = valid_ff[2];
   assign rsp_clipped = clip_x | clip_y | clip_z;

endmodule

`default_nettype wire

### dv/world_point_checker.sv
// ----------------------------------------------------------------------------
// world_point_checker: scoreboard for the depth pixel to world point block
// Watches the pixel, point and register channels, computes the expected
// world point of every accepted pixel beat from its own copy of the
// registers, and compares each accepted point beat in order.
// ----------------------------------------------------------------------------
module world_point_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   // Pixel channel
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic        [dpw_pkg::DEPTH_W-1:0]   req_depth_mm,
   input  logic        [dpw_pkg::COL_W-1:0]     req_column,
   input  logic        [dpw_pkg::ROW_W-1:0]     req_row_index,
   // Point channel
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic        [dpw_pkg::WORLD_W-1:0]   rsp_world_x,
   input  logic        [dpw_pkg::WORLD_W-1:0]   rsp_world_y,
   input  logic        [dpw_pkg::WORLD_W-1:0]   rsp_world_z,
   input  logic                                 rsp_clipped,
   // Configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic        [dpw_pkg::CSR_AW-1:0]    paddr,
   input  logic        [dpw_pkg::CSR_DW-1:0]    pwdata,
   // Results for the testbench top
   output int                                   mismatch_count,
   output int                                   points_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dpw_pkg::*;

   typedef struct packed {
      logic [WORLD_W-1:0] x;
      logic [WORLD_W-1:0] y;
      logic [WORLD_W-1:0] z;
      logic               clipped;
   } world_point_type;

   localparam longint WORLD_MAX = 262143;
   localparam longint WORLD_MIN = -262144;

   // Shadow copy of the register file
   logic [INV_W-1:0]    inv_fx;
   logic [INV_W-1:0]    inv_fy;
   logic [CENTER_W-1:0] cx;
   logic [CENTER_W-1:0] cy;
   pose_row_type        pose_x;
   pose_row_type        pose_y;
   pose_row_type        pose_z;

   world_point_type expected_points[$];

   // Divide by 2^s, rounding halves toward plus infinity
   function automatic longint round_half_up(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // One transform row applied to a Q.8 camera point, rounded to whole mm
   function automatic longint row_to_mm(input pose_row_type pr, input longint px,
                                        input longint py, input longint pz);
      longint acc;
      acc = longint'($signed(pr.r0)) * px + longint'($signed(pr.r1)) * py
          + longint'($signed(pr.r2)) * pz
          + longint'($signed(pr.t)) * (longint'(1) <<< 22);
      return round_half_up(acc, 22);
   endfunction

   function automatic logic [WORLD_W-1:0] clamp_mm(input longint w);
      longint lim;
      lim = (w > WORLD_MAX) ? WORLD_MAX : (w < WORLD_MIN) ? WORLD_MIN : w;
      return lim[WORLD_W-1:0];
   endfunction

   function automatic bit off_scale(input longint w);
      return (w > WORLD_MAX) || (w < WORLD_MIN);
   endfunction

   // Back-project one pixel and move it into the world frame
   function automatic world_point_type project_pixel(input logic [DEPTH_W-1:0] depth,
                                                     input logic [COL_W-1:0]   col,
                                                     input logic [ROW_W-1:0]   row);
      longint d, dx, dy, cxl, cyl, fxl, fyl, px, py, pz, wx, wy, wz;
      world_point_type pt;
      d   = depth;
      cxl = cx;
      cyl = cy;
      fxl = inv_fx;
      fyl = inv_fy;
      dx  = col;
      dy  = row;
      dx  = dx * 16 - cxl;
      dy  = dy * 16 - cyl;
      px  = round_half_up(dx * d * fxl, 20);
      py  = round_half_up(dy * d * fyl, 20);
      pz  = -d * 256;
      wx  = row_to_mm(pose_x, px, py, pz);
      wy  = row_to_mm(pose_y, px, py, pz);
      wz  = row_to_mm(pose_z, px, py, pz);
      pt.x = clamp_mm(wx);
      pt.y = clamp_mm(wy);
      pt.z = clamp_mm(wz);
      pt.clipped = off_scale(wx) | off_scale(wy) | off_scale(wz);
      return pt;
   endfunction

   // Track register writes, queue predictions, compare point beats
   always @(posedge clock) begin : track
      world_point_type want;
      if (reset) begin
         inv_fx <= INV_FOCAL_RST;
         inv_fy <= INV_FOCAL_RST;
         cx     <= CENTER_X_RST;
         cy     <= CENTER_Y_RST;
         pose_x <= POSE_X_RST;
         pose_y <= POSE_Y_RST;
         pose_z <= POSE_Z_RST;
         expected_points.delete();
         points_pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               REG_INV_FOCAL_X: inv_fx <= pwdata[INV_W-1:0];
               REG_INV_FOCAL_Y: inv_fy <= pwdata[INV_W-1:0];
               REG_CENTER_X:    cx     <= pwdata[CENTER_W-1:0];
               REG_CENTER_Y:    cy     <= pwdata[CENTER_W-1:0];
               REG_POSE_ROW_X:  pose_x <= pwdata;
               REG_POSE_ROW_Y:  pose_y <= pwdata;
               REG_POSE_ROW_Z:  pose_z <= pwdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: point beat with none expected: x=%0d y=%0d z=%0d clip=%0b",
                           $time, $signed(rsp_world_x), $signed(rsp_world_y),
                           $signed(rsp_world_z), rsp_clipped);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp_world_x !== want.x || rsp_world_y !== want.y ||
                   rsp_world_z !== want.z || rsp_clipped !== want.clipped) begin
                  if (mismatch_count < 10)
                     $display("%0t: point mismatch: got x=%0d y=%0d z=%0d clip=%0b, want x=%0d y=%0d z=%0d clip=%0b",
                              $time, $signed(rsp_world_x), $signed(rsp_world_y),
                              $signed(rsp_world_z), rsp_clipped, $signed(want.x),
                              $signed(want.y), $signed(want.z), want.clipped);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_points.push_back(project_pixel(req_depth_mm, req_column, req_row_index));
         points_pending <= expected_points.size();
      end
   end

endmodule

### dv/depth_pixel_to_world_point_top_tb.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_top_tb: testbench for the world point converter
// Loads a series of camera and pose settings over the register port, from
// the reset values through the extremes to random poses, and streams
// directed and random depth pixels under several idle and stall patterns.
// A separate checker predicts and compares every point beat.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dpw_pkg::*;

   localparam logic [2:0] UNMAPPED_INDEX = 3'd7;
   localparam int         DRAIN_CYCLES   = 20;
   localparam int         PHASES         = 19;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [DEPTH_W-1:0]  req_depth_mm  = '0;
   logic [COL_W-1:0]    req_column    = '0;
   logic [ROW_W-1:0]    req_row_index = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [WORLD_W-1:0]  rsp_world_x;
   logic [WORLD_W-1:0]  rsp_world_y;
   logic [WORLD_W-1:0]  rsp_world_z;
   logic                rsp_clipped;
   logic                psel          = 1'b0;
   logic                penable       = 1'b0;
   logic                pwrite        = 1'b0;
   logic [CSR_AW-1:0]   paddr         = '0;
   logic [CSR_DW-1:0]   pwdata        = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   int mismatch_count;
   int points_pending;
   int idle_pct  = 0;
   int stall_pct = 0;

   depth_pixel_to_world_point_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_depth_mm  (req_depth_mm),
      .req_column    (req_column),
      .req_row_index (req_row_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_world_x   (rsp_world_x),
      .rsp_world_y   (rsp_world_y),
      .rsp_world_z   (rsp_world_z),
      .rsp_clipped   (rsp_clipped),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   world_point_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_depth_mm   (req_depth_mm),
      .req_column     (req_column),
      .req_row_index  (req_row_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_world_x    (rsp_world_x),
      .rsp_world_y    (rsp_world_y),
      .rsp_world_z    (rsp_world_z),
      .rsp_clipped    (rsp_clipped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .points_pending (points_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the point channel at the current rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Hard stop in case the pipeline hangs
   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic [63:0] pack_pose(input logic [15:0] r0, input logic [15:0] r1,
                                             input logic [15:0] r2, input logic [15:0] t);
      pose_row_type pr;
      pr.r0 = r0;
      pr.r1 = r1;
      pr.r2 = r2;
      pr.t  = t;
      return pr;
   endfunction

   // Setup cycle, then access cycle; hold until pready
   task automatic write_register(input logic [2:0] index, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_camera(input logic [23:0] ifx, input logic [23:0] ify,
                              input logic [13:0] ccx, input logic [13:0] ccy,
                              input logic [63:0] prx, input logic [63:0] pry,
                              input logic [63:0] prz);
      write_register(REG_INV_FOCAL_X, {40'd0, ifx});
      write_register(REG_INV_FOCAL_Y, {40'd0, ify});
      write_register(REG_CENTER_X, {50'd0, ccx});
      write_register(REG_CENTER_Y, {50'd0, ccy});
      write_register(REG_POSE_ROW_X, prx);
      write_register(REG_POSE_ROW_Y, pry);
      write_register(REG_POSE_ROW_Z, prz);
   endtask

   // Offer one pixel beat, with a random gap first, and hold until taken
   task automatic send_pixel(input logic [15:0] depth, input logic [9:0] col,
                             input logic [8:0] row);
      int gap;
      gap = 0;
      while (gap < 8 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_depth_mm  <= depth;
      req_column    <= col;
      req_row_index <= row;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly in-image pixels at plausible depths, some anywhere in the fields
   task automatic send_random_pixel();
      int pick;
      logic [15:0] depth;
      logic [9:0]  col;
      logic [8:0]  row;
      pick = $urandom_range(99);
      if (pick < 12)      depth = '0;
      else if (pick < 70) depth = 16'($urandom_range(8000, 300));
      else if (pick < 88) depth = 16'($urandom_range(65535));
      else                depth = 16'($urandom_range(65535, 60000));
      col = ($urandom_range(99) < 80) ? 10'($urandom_range(639)) : 10'($urandom_range(1023));
      row = ($urandom_range(99) < 80) ? 9'($urandom_range(479)) : 9'($urandom_range(511));
      send_pixel(depth, col, row);
   endtask

   function automatic logic [15:0] rotation_term();
      return 16'($urandom_range(32768) - 16384);
   endfunction

   // Drop valid and hold until every point has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (points_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: corners, center, zero depth, outside the image
      send_pixel(16'd0, 10'd0, 9'd0);
      send_pixel(16'd65535, 10'd0, 9'd0);
      send_pixel(16'd65535, 10'd639, 9'd479);
      send_pixel(16'd65535, 10'd1023, 9'd511);
      send_pixel(16'd0, 10'd1023, 9'd511);
      send_pixel(16'd1, 10'd320, 9'd240);
      send_pixel(16'd1000, 10'd320, 9'd240);
      send_pixel(16'd1000, 10'd0, 9'd240);
      send_pixel(16'd1000, 10'd639, 9'd240);
      send_pixel(16'd1000, 10'd320, 9'd0);
      send_pixel(16'd1000, 10'd320, 9'd479);
      send_pixel(16'd65535, 10'd640, 9'd480);
      send_pixel(16'd32768, 10'd512, 9'd256);
      send_pixel(16'd12345, 10'd1, 9'd1);
      send_pixel(16'd65534, 10'd1022, 9'd510);
      send_pixel(16'd2, 10'd319, 9'd239);

      for (int phase = 1; phase < PHASES; phase++) begin
         drain();
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 45; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 45; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         case (phase)
            // Everything at its top value
            1: load_camera(24'hFFFFFF, 24'hFFFFFF, 14'h3FFF, 14'h3FFF,
                           '1, '1, '1);
            // Everything zero; a write to the unused slot must change nothing
            2: begin
               load_camera(24'd0, 24'd0, 14'd0, 14'd0, '0, '0, '0);
               write_register(UNMAPPED_INDEX, {$urandom, $urandom});
            end
            // Most negative rotation, largest translation
            3: load_camera(24'd65536, 24'd16, 14'd0, 14'h3FFF,
                           pack_pose(16'h8000, 16'h8000, 16'h8000, 16'h7FFF),
                           pack_pose(16'h8000, 16'h8000, 16'h8000, 16'h7FFF),
                           pack_pose(16'h8000, 16'h8000, 16'h8000, 16'h7FFF));
            // Largest rotation, most negative translation
            4: load_camera(24'd31957, 24'd200000, 14'h3FFF, 14'd0,
                           pack_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000),
                           pack_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000),
                           pack_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
            default: begin
               if ($urandom_range(3) == 0)
                  load_camera(24'($urandom_range(24'hFFFFFF)),
                              24'($urandom_range(24'hFFFFFF)),
                              14'($urandom_range(16383)), 14'($urandom_range(16383)),
                              {$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom});
               else
                  load_camera(24'($urandom_range(140000, 8000)),
                              24'($urandom_range(140000, 8000)),
                              14'($urandom_range(16383)), 14'($urandom_range(16383)),
                              pack_pose(rotation_term(), rotation_term(), rotation_term(),
                                        16'($urandom)),
                              pack_pose(rotation_term(), rotation_term(), rotation_term(),
                                        16'($urandom)),
                              pack_pose(rotation_term(), rotation_term(), rotation_term(),
                                        16'($urandom)));
            end
         endcase
         count = (phase <= 4) ? 50 : 100;
         for (int n = 0; n < count; n++) send_random_pixel();
      end

      drain();
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
